FILE: src/sha1s_pkg.sv
`timescale 1ns / 1ps

package sha1s_pkg;

  // Block and digest geometry
  localparam int BLK_WORDS  = 16;
  localparam int BLK_AW     = 4;
  localparam int DIG_WORDS  = 5;
  localparam int ROUNDS     = 80;
  localparam int CNT_W      = 61;

  // Command queue between front and back
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = 2;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_IDX   = 3'(DIG_WORDS - 1);
  localparam logic [5:0] LAST_POS   = 6'd63;
  localparam logic [7:0] PAD_BYTE   = 8'h80;

  localparam logic [31:0] IV [DIG_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // One queued item after classification
  typedef struct packed {
    logic [7:0] data_byte;
    logic       present;
    logic       last;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } core_state_t;

  // What follows a compression
  typedef enum logic [1:0] {
    STG_DATA,
    STG_PAD1,
    STG_FINAL
  } stage_t;

  function automatic logic [31:0] rol1(input logic [31:0] x);
    rol1 = {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rol5(input logic [31:0] x);
    rol5 = {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] x);
    rol30 = {x[1:0], x[31:2]};
  endfunction

  // Round function by round number
  function automatic logic [31:0] round_f(input logic [6:0] rnd, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (rnd < 7'd20) begin
      round_f = (b & c) | (~b & d);
    end else if (rnd < 7'd40) begin
      round_f = b ^ c ^ d;
    end else if (rnd < 7'd60) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] rnd);
    if (rnd < 7'd20) begin
      round_k = K0;
    end else if (rnd < 7'd40) begin
      round_k = K1;
    end else if (rnd < 7'd60) begin
      round_k = K2;
    end else begin
      round_k = K3;
    end
  endfunction

  // Big-endian byte insert; lane 0 clears the rest of the word
  function automatic logic [31:0] put_word(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    case (lane)
      2'd0:    put_word = {b, 24'h0};
      2'd1:    put_word = {w[31:24], b, 16'h0};
      2'd2:    put_word = {w[31:16], b, 8'h0};
      default: put_word = {w[31:8], b};
    endcase
  endfunction

  // Padding: keep bytes before the marker, 0x80 at it, zeros after
  function automatic logic [31:0] pad_word(input logic [31:0] w, input logic [BLK_AW-1:0] j,
                                           input logic [BLK_AW-1:0] widx,
                                           input logic [1:0] lane);
    if (j < widx) begin
      pad_word = w;
    end else if (j > widx) begin
      pad_word = 32'h0;
    end else begin
      pad_word = put_word(w, lane, PAD_BYTE);
    end
  endfunction

endpackage

FILE: src/sha1s_if.sv
`timescale 1ns / 1ps

// Input item channel
interface sha1s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

// Digest word channel
interface sha1s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: src/sha1s_front.sv
`timescale 1ns / 1ps

module sha1s_front (
  sha1s_in_if.sink       in_ch,
  input  logic           q_full,
  output logic           q_push,
  output sha1s_pkg::cmd_t q_cmd
);

  // Take items while the queue has room; items with neither byte nor end are dropped
  assign in_ch.ready     = !q_full;
  assign q_push          = in_ch.valid && !q_full &&
                           (in_ch.byte_present || in_ch.end_of_message);
  assign q_cmd.data_byte = in_ch.data_byte;
  assign q_cmd.present   = in_ch.byte_present;
  assign q_cmd.last      = in_ch.end_of_message;

endmodule

FILE: src/sha1s_fifo.sv
`timescale 1ns / 1ps

module sha1s_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sha1s_pkg::cmd_t push_cmd,
  input  logic            pop,
  output sha1s_pkg::cmd_t head_cmd,
  output logic            full,
  output logic            empty
);

  sha1s_pkg::cmd_t                mem [sha1s_pkg::Q_DEPTH];
  logic [sha1s_pkg::Q_AW-1:0]     wr_ptr_r;
  logic [sha1s_pkg::Q_AW-1:0]     rd_ptr_r;
  logic [sha1s_pkg::Q_AW:0]       fill_r;
  logic                           do_push;
  logic                           do_pop;

  assign full     = (fill_r == (sha1s_pkg::Q_AW + 1)'(sha1s_pkg::Q_DEPTH));
  assign empty    = (fill_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill_r <= fill_r + 1'b1;
        2'b01:   fill_r <= fill_r - 1'b1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // Fill level never exceeds the depth
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (sha1s_pkg::Q_AW + 1)'(sha1s_pkg::Q_DEPTH))
    else $error("queue fill level out of range");

endmodule

FILE: src/sha1s_core.sv
`timescale 1ns / 1ps

module sha1s_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  sha1s_pkg::cmd_t q_cmd,
  output logic            q_pop,
  sha1s_out_if.source     out_ch
);

  sha1s_pkg::core_state_t state_r, state_nxt;
  sha1s_pkg::stage_t      stage_r, stage_nxt;
  logic                   last_r, last_nxt;

  logic [31:0]                      blk_r [sha1s_pkg::BLK_WORDS];
  logic [31:0]                      cv_r  [sha1s_pkg::DIG_WORDS];
  logic [31:0]                      a_r, b_r, c_r, d_r, e_r;
  logic [6:0]                       rnd_r;
  logic [sha1s_pkg::CNT_W-1:0]      count_r;
  logic [2:0]                       idx_r;

  logic        out_valid_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_index_r;
  logic        out_last_r;

  logic put_byte, start_c, do_pad, do_len, emit;

  logic [sha1s_pkg::BLK_AW-1:0] widx;
  logic [1:0]                   lane;
  logic                         pad_full;
  logic [63:0]                  len_bits;
  logic [31:0]                  w_next;
  logic [31:0]                  t_sum;

  assign widx     = count_r[5:2];
  assign lane     = count_r[1:0];
  assign pad_full = (count_r[5:3] == 3'b111);
  assign len_bits = {count_r, 3'b000};
  assign w_next   = sha1s_pkg::rol1(blk_r[13] ^ blk_r[8] ^ blk_r[2] ^ blk_r[0]);
  assign t_sum    = sha1s_pkg::rol5(a_r) + sha1s_pkg::round_f(rnd_r, b_r, c_r, d_r) +
                    e_r + sha1s_pkg::round_k(rnd_r) + blk_r[0];

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha1s_pkg::ST_IDLE;
      stage_r <= sha1s_pkg::STG_DATA;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      stage_r <= stage_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    last_nxt  = last_r;
    q_pop     = 1'b0;
    put_byte  = 1'b0;
    start_c   = 1'b0;
    do_pad    = 1'b0;
    do_len    = 1'b0;
    emit      = 1'b0;
    unique case (state_r)
      sha1s_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          last_nxt = q_cmd.last;
          if (q_cmd.present) begin
            put_byte = 1'b1;
            if (count_r[5:0] == sha1s_pkg::LAST_POS) begin
              start_c   = 1'b1;
              stage_nxt = sha1s_pkg::STG_DATA;
              state_nxt = sha1s_pkg::ST_ROUND;
            end else if (q_cmd.last) begin
              state_nxt = sha1s_pkg::ST_PAD;
            end
          end else if (q_cmd.last) begin
            state_nxt = sha1s_pkg::ST_PAD;
          end
        end
      end
      sha1s_pkg::ST_PAD: begin
        do_pad    = 1'b1;
        start_c   = 1'b1;
        stage_nxt = pad_full ? sha1s_pkg::STG_PAD1 : sha1s_pkg::STG_FINAL;
        state_nxt = sha1s_pkg::ST_ROUND;
      end
      sha1s_pkg::ST_LEN: begin
        do_len    = 1'b1;
        start_c   = 1'b1;
        stage_nxt = sha1s_pkg::STG_FINAL;
        state_nxt = sha1s_pkg::ST_ROUND;
      end
      sha1s_pkg::ST_ROUND: begin
        if (rnd_r == sha1s_pkg::LAST_ROUND) begin
          state_nxt = sha1s_pkg::ST_ADD;
        end
      end
      sha1s_pkg::ST_ADD: begin
        case (stage_r)
          sha1s_pkg::STG_DATA:  state_nxt = last_r ? sha1s_pkg::ST_PAD : sha1s_pkg::ST_IDLE;
          sha1s_pkg::STG_PAD1:  state_nxt = sha1s_pkg::ST_LEN;
          default:              state_nxt = sha1s_pkg::ST_EMIT;
        endcase
      end
      sha1s_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          emit = 1'b1;
          if (idx_r == sha1s_pkg::LAST_IDX) begin
            state_nxt = sha1s_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sha1s_pkg::ST_IDLE;
    endcase
  end

  // Byte count and digest word index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      if (put_byte) begin
        count_r <= count_r + 1'b1;
      end else if (emit && idx_r == sha1s_pkg::LAST_IDX) begin
        count_r <= '0;
      end
      if (emit) begin
        idx_r <= (idx_r == sha1s_pkg::LAST_IDX) ? 3'd0 : idx_r + 3'd1;
      end
    end
  end

  // Chaining value: feed-forward add, restored after the last digest word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < sha1s_pkg::DIG_WORDS; i++) begin
        cv_r[i] <= sha1s_pkg::IV[i];
      end
    end else if (state_r == sha1s_pkg::ST_ADD) begin
      cv_r[0] <= cv_r[0] + a_r;
      cv_r[1] <= cv_r[1] + b_r;
      cv_r[2] <= cv_r[2] + c_r;
      cv_r[3] <= cv_r[3] + d_r;
      cv_r[4] <= cv_r[4] + e_r;
    end else if (emit && idx_r == sha1s_pkg::LAST_IDX) begin
      for (int i = 0; i < sha1s_pkg::DIG_WORDS; i++) begin
        cv_r[i] <= sha1s_pkg::IV[i];
      end
    end
  end

  // Round counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_r <= '0;
    end else if (start_c) begin
      rnd_r <= '0;
    end else if (state_r == sha1s_pkg::ST_ROUND) begin
      rnd_r <= (rnd_r == sha1s_pkg::LAST_ROUND) ? 7'd0 : rnd_r + 7'd1;
    end
  end

  // Working variables, one round per cycle
  always_ff @(posedge clk) begin
    if (start_c) begin
      a_r <= cv_r[0];
      b_r <= cv_r[1];
      c_r <= cv_r[2];
      d_r <= cv_r[3];
      e_r <= cv_r[4];
    end else if (state_r == sha1s_pkg::ST_ROUND) begin
      a_r <= t_sum;
      b_r <= a_r;
      c_r <= sha1s_pkg::rol30(b_r);
      d_r <= c_r;
      e_r <= d_r;
    end
  end

  // Block buffer; doubles as the 16-word schedule window during rounds
  always_ff @(posedge clk) begin
    if (put_byte) begin
      blk_r[widx] <= sha1s_pkg::put_word(blk_r[widx], lane, q_cmd.data_byte);
    end else if (do_pad) begin
      for (int j = 0; j < sha1s_pkg::BLK_WORDS - 2; j++) begin
        blk_r[j] <= sha1s_pkg::pad_word(blk_r[j], sha1s_pkg::BLK_AW'(j), widx, lane);
      end
      // length fits in this block unless the marker landed in the last 8 bytes
      if (pad_full) begin
        blk_r[14] <= sha1s_pkg::pad_word(blk_r[14], 4'd14, widx, lane);
        blk_r[15] <= sha1s_pkg::pad_word(blk_r[15], 4'd15, widx, lane);
      end else begin
        blk_r[14] <= len_bits[63:32];
        blk_r[15] <= len_bits[31:0];
      end
    end else if (do_len) begin
      for (int j = 0; j < sha1s_pkg::BLK_WORDS - 2; j++) begin
        blk_r[j] <= 32'h0;
      end
      blk_r[14] <= len_bits[63:32];
      blk_r[15] <= len_bits[31:0];
    end else if (state_r == sha1s_pkg::ST_ROUND) begin
      for (int j = 0; j < sha1s_pkg::BLK_WORDS - 1; j++) begin
        blk_r[j] <= blk_r[j+1];
      end
      blk_r[15] <= w_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_word_r  <= cv_r[idx_r];
      out_index_r <= idx_r;
      out_last_r  <= (idx_r == sha1s_pkg::LAST_IDX);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digest_word = out_word_r;
  assign out_ch.word_index  = out_index_r;
  assign out_ch.last_word   = out_last_r;

  // Round counter stays within the 80 rounds
  a_rnd_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= sha1s_pkg::LAST_ROUND)
    else $error("round counter out of range");

  // Final compression is followed by the digest output
  a_final_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sha1s_pkg::ST_ADD && stage_r == sha1s_pkg::STG_FINAL)
      |=> state_r == sha1s_pkg::ST_EMIT)
    else $error("final compression not followed by output");

  // Last flag only on the fifth word
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> out_index_r == sha1s_pkg::LAST_IDX)
    else $error("last flag on wrong digest word");

endmodule

FILE: src/sha1_stream_hash.sv
`timescale 1ns / 1ps
// Operation: a byte item is taken by the hashing core while it is idle; a byte that fills a block
//   starts a compression (80 rounds at one round per cycle, then a feed-forward add).
// End of message: each padded block (one or two) gets a setup step, the 80 rounds and the add,
//   then five digest words follow, one per cycle when the sink is ready.
// The core takes no new byte while a block is compressed; the queue holds up to four items.
// Reset (synchronous, rst_n low) restores the initial chaining value and clears the count.
module sha1_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  sha1s_in_if.sink    in_ch,
  sha1s_out_if.source out_ch
);

  sha1s_pkg::cmd_t push_cmd;
  sha1s_pkg::cmd_t head_cmd;
  logic            push;
  logic            pop;
  logic            q_full;
  logic            q_empty;

  sha1s_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (push),
    .q_cmd  (push_cmd)
  );

  sha1s_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  sha1s_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_cmd   (head_cmd),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule
